// ===== sv/paging_frame_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// paging_frame_allocator_macros
// Assertion macros used by the checker of the frame allocator.
// ----------------------------------------------------------------------------
`ifndef PAGING_FRAME_ALLOCATOR_MACROS_SVH
`define PAGING_FRAME_ALLOCATOR_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define PFA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfa assertion failed");

// next-cycle implication
`define PFA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfa assertion failed");

`endif

// ===== sv/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg
// Types, field widths and codes of the paging frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package pfa_pkg;
	localparam int CMD_W  = 2;
	localparam int PID_W  = 16;
	localparam int SIZE_W = 16;
	localparam int STS_W  = 3;
	localparam int IDX_W  = 6;
	localparam int FRM_W  = 6;
	localparam int PC_W   = 7;
	localparam int FC_W   = 7;
	localparam int PSZ_W  = 11;
	localparam int CFG_W  = 11;
	localparam int CFGI_W = 1;

	localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DEALLOC = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_LIST    = 2'd3;

	localparam logic [STS_W-1:0] STS_OK       = 3'd0;
	localparam logic [STS_W-1:0] STS_NOFIT    = 3'd1;
	localparam logic [STS_W-1:0] STS_NOTFOUND = 3'd2;
	localparam logic [STS_W-1:0] STS_FULL     = 3'd3;
	localparam logic [STS_W-1:0] STS_EMPTY    = 3'd4;

	localparam logic [CFGI_W-1:0] REG_FRAME_COUNT = 1'b0;
	localparam logic [CFGI_W-1:0] REG_PAGE_SIZE   = 1'b1;

	localparam logic [FC_W-1:0]  FRAME_COUNT_RST = 7'd64;
	localparam logic [PSZ_W-1:0] PAGE_SIZE_RST   = 11'd4;

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_DIV, ST_ARD, ST_AEM, ST_SRCH, ST_DRD,
		ST_DPUSH, ST_QRD, ST_QEM, ST_LRD, ST_LEM, ST_ONE
	} state_t;
endpackage
`default_nettype wire

// ===== sv/pfa_req_if.sv =====
// ----------------------------------------------------------------------------
// pfa_req_if
// Request channel of the frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none
interface pfa_req_if;
	logic                      valid;
	logic                      ready;
	logic [pfa_pkg::CMD_W-1:0]  command;
	logic [pfa_pkg::PID_W-1:0]  process_id;
	logic [pfa_pkg::SIZE_W-1:0] request_size_kb;

	modport source (output valid, command, process_id, request_size_kb, input ready);
	modport sink (input valid, command, process_id, request_size_kb, output ready);
endinterface
`default_nettype wire

// ===== sv/pfa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pfa_rsp_if
// Result channel of the frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none
interface pfa_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [pfa_pkg::STS_W-1:0] status;
	logic [pfa_pkg::IDX_W-1:0] page_index;
	logic [pfa_pkg::FRM_W-1:0] frame_number;
	logic                     entry_valid;
	logic [pfa_pkg::PC_W-1:0]  page_count;
	logic                     last;

	modport source (output valid, status, page_index, frame_number, entry_valid,
		page_count, last, input ready);
	modport sink (input valid, status, page_index, frame_number, entry_valid,
		page_count, last, output ready);
endinterface
`default_nettype wire

// ===== sv/pfa_ram.sv =====
// ----------------------------------------------------------------------------
// pfa_ram
// Generic RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module pfa_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== sv/pfa_div.sv =====
// ----------------------------------------------------------------------------
// pfa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pfa_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [pfa_pkg::SIZE_W-1:0]  dividend,
	input  wire logic [pfa_pkg::PSZ_W-1:0]   divisor,
	output logic                             done,
	output logic      [pfa_pkg::SIZE_W-1:0]  quotient
);
	logic                         busy_q;
	logic [3:0]                   cnt_q;
	logic [pfa_pkg::PSZ_W-1:0]    rem_q;
	logic [pfa_pkg::PSZ_W-1:0]    dsr_q;
	logic [pfa_pkg::SIZE_W-1:0]   quo_q;
	logic                         done_q;
	logic [pfa_pkg::PSZ_W:0]      sh;
	logic                         ge;
	logic [pfa_pkg::PSZ_W:0]      nrem;

	assign sh   = {rem_q, quo_q[pfa_pkg::SIZE_W-1]};
	assign ge   = sh >= {1'b0, dsr_q};
	assign nrem = ge ? sh - {1'b0, dsr_q} : sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[pfa_pkg::SIZE_W-2:0], ge};
			rem_q <= nrem[pfa_pkg::PSZ_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// ===== sv/paging_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// paging_frame_allocator
// Free-frame ring paging allocator with a per-process page table.
// ----------------------------------------------------------------------------
// Requests arrive on req (command, process_id, request_size_kb); results leave
// on rsp, one or more per request, the final one marked by last. Frame count
// and page size are to be written on the cfg port only while the block is
// idle; the block itself does not enforce this. One request is handled at a
// time; req.ready is high only while idle. Allocate: the divider state, then
// per page a ring read, then a result. Deallocate and query: a scan of the
// table slots (up to PROCESS_SLOTS), then per page a frame read, then a ring
// push (deallocate) or a result (query). List: per free frame a ring read, then
// a result. The RAMs' registered read sets the read step per page. Reset, and
// any write of the frame count, runs a fill pass over all FRAMES ring entries
// that loads the free ring with frames in order; no request is taken then. A
// stalled receiver holds the result register; the sequencer waits on it.
// ----------------------------------------------------------------------------
`default_nettype none
module paging_frame_allocator #(
	parameter int FRAMES        = 64,
	parameter int PROCESS_SLOTS = 16,
	parameter int MAX_PAGES     = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	pfa_req_if.sink                           req,
	pfa_rsp_if.source                         rsp,
	input  wire logic                         cfg_we,
	input  wire logic [pfa_pkg::CFGI_W-1:0]   cfg_index,
	input  wire logic [pfa_pkg::CFG_W-1:0]    cfg_wdata
);
	localparam int RA_W = $clog2(FRAMES);
	localparam int CW   = $clog2(FRAMES + 1);
	localparam int SW   = $clog2(PROCESS_SLOTS);
	localparam int FD   = PROCESS_SLOTS * MAX_PAGES;
	localparam int FA_W = $clog2(FD);
	localparam logic [RA_W:0] FRAMES_L = (RA_W + 1)'(FRAMES);

	pfa_pkg::state_t state_q, state_d;

	logic [pfa_pkg::PSZ_W-1:0]  psz_q;
	logic [RA_W-1:0]            init_q;
	logic [RA_W-1:0]            head_q;
	logic [CW-1:0]              cnt_q;
	logic [SW:0]                used_q;
	logic [SW:0]                idx_q;
	logic [SW-1:0]              slot_q;
	logic [pfa_pkg::IDX_W-1:0]  i_q;
	logic [pfa_pkg::PC_W-1:0]   n_q;
	logic [pfa_pkg::CMD_W-1:0]  cmd_q;
	logic [pfa_pkg::PID_W-1:0]  pid_q;
	logic                       szero_q;
	logic [pfa_pkg::STS_W-1:0]  one_sts_q;
	logic [pfa_pkg::PC_W-1:0]   one_pc_q;

	logic [pfa_pkg::PID_W-1:0]  owner_q   [PROCESS_SLOTS];
	logic [pfa_pkg::PC_W-1:0]   spages_q  [PROCESS_SLOTS];
	logic                       removed_q [PROCESS_SLOTS];

	logic                       rsp_valid_q;
	logic [pfa_pkg::STS_W-1:0]  rsp_status_q;
	logic [pfa_pkg::IDX_W-1:0]  rsp_pidx_q;
	logic [pfa_pkg::FRM_W-1:0]  rsp_frame_q;
	logic                       rsp_ev_q;
	logic [pfa_pkg::PC_W-1:0]   rsp_pc_q;
	logic                       rsp_last_q;

	logic                       accept, out_free, cfg_fc, div_start, div_done;
	logic [pfa_pkg::SIZE_W-1:0] quo;
	logic [pfa_pkg::PSZ_W-1:0]  psz_eff;
	logic [CW-1:0]              fc_eff;
	logic [pfa_pkg::PC_W-1:0]   ip1;
	logic                       last_i;
	logic [RA_W:0]              lsum, tsum;
	logic [RA_W-1:0]            laddr, taddr, head_nx;
	logic [SW-1:0]              idx_s;
	logic                       hit, bad, full;
	logic                       ring_we, ring_re, fr_we, fr_re;
	logic [RA_W-1:0]            ring_wa, ring_ra;
	logic [pfa_pkg::FRM_W-1:0]  ring_wd, ring_rd, fr_rd;
	logic [FA_W-1:0]            fr_addr;
	logic                       emit;
	logic [pfa_pkg::STS_W-1:0]  e_sts;
	logic [pfa_pkg::FRM_W-1:0]  e_frame;
	logic                       e_ev;
	logic [pfa_pkg::PC_W-1:0]   e_pc;
	logic                       e_last;

	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign cfg_fc   = cfg_we && (cfg_index == pfa_pkg::REG_FRAME_COUNT);
	assign psz_eff  = (psz_q == '0) ? pfa_pkg::PSZ_W'(1) : psz_q;
	assign fc_eff   = (cfg_wdata[pfa_pkg::FC_W-1:0] == '0) ? CW'(1) :
		(cfg_wdata[pfa_pkg::FC_W-1:0] > pfa_pkg::FC_W'(FRAMES)) ? CW'(FRAMES) :
		CW'(cfg_wdata[pfa_pkg::FC_W-1:0]);
	assign ip1      = {1'b0, i_q} + pfa_pkg::PC_W'(1);
	assign last_i   = ip1 == n_q;
	assign lsum     = {1'b0, head_q} + (RA_W + 1)'(i_q);
	assign laddr    = (lsum >= FRAMES_L) ? RA_W'(lsum - FRAMES_L) : RA_W'(lsum);
	assign tsum     = {1'b0, head_q} + (RA_W + 1)'(cnt_q);
	assign taddr    = (tsum >= FRAMES_L) ? RA_W'(tsum - FRAMES_L) : RA_W'(tsum);
	assign head_nx  = (head_q == RA_W'(FRAMES - 1)) ? '0 : head_q + RA_W'(1);
	assign idx_s    = idx_q[SW-1:0];
	assign hit      = !removed_q[idx_s] && (owner_q[idx_s] == pid_q);
	assign bad      = szero_q || (quo > pfa_pkg::SIZE_W'(cnt_q)) ||
		(quo > pfa_pkg::SIZE_W'(MAX_PAGES));
	assign full     = used_q == (SW + 1)'(PROCESS_SLOTS);
	assign fr_addr  = FA_W'(slot_q * MAX_PAGES + i_q);
	assign div_start = accept && (req.command == pfa_pkg::CMD_ALLOC);

	pfa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (req.request_size_kb),
		.divisor  (psz_eff),
		.done     (div_done),
		.quotient (quo)
	);

	pfa_ram #(.WIDTH(pfa_pkg::FRM_W), .DEPTH(FRAMES)) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_wa),
		.wdata (ring_wd),
		.re    (ring_re),
		.raddr (ring_ra),
		.rdata (ring_rd)
	);

	pfa_ram #(.WIDTH(pfa_pkg::FRM_W), .DEPTH(FD)) u_frames (
		.clk   (clk),
		.we    (fr_we),
		.waddr (fr_addr),
		.wdata (ring_rd),
		.re    (fr_re),
		.raddr (fr_addr),
		.rdata (fr_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfa_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		req.ready = 1'b0;
		ring_we = 1'b0;
		ring_wa = taddr;
		ring_wd = fr_rd;
		ring_re = 1'b0;
		ring_ra = head_q;
		fr_we = 1'b0;
		fr_re = 1'b0;
		emit = 1'b0;
		e_sts = pfa_pkg::STS_OK;
		e_frame = ring_rd;
		e_ev = 1'b1;
		e_pc = n_q;
		e_last = last_i;
		unique case (state_q)
			pfa_pkg::ST_INIT: begin
				ring_we = 1'b1;
				ring_wa = init_q;
				ring_wd = pfa_pkg::FRM_W'(init_q);
				if (init_q == RA_W'(FRAMES - 1)) begin
					state_d = pfa_pkg::ST_IDLE;
				end
			end
			pfa_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					unique case (req.command)
						pfa_pkg::CMD_ALLOC: state_d = pfa_pkg::ST_DIV;
						pfa_pkg::CMD_DEALLOC,
						pfa_pkg::CMD_QUERY: state_d = pfa_pkg::ST_SRCH;
						default: state_d = (cnt_q == '0) ? pfa_pkg::ST_ONE :
							pfa_pkg::ST_LRD;
					endcase
				end
			end
			pfa_pkg::ST_DIV: begin
				if (div_done) begin
					if (bad || full || quo == '0) begin
						state_d = pfa_pkg::ST_ONE;
					end else begin
						state_d = pfa_pkg::ST_ARD;
					end
				end
			end
			pfa_pkg::ST_ARD: begin
				ring_re = 1'b1;
				state_d = pfa_pkg::ST_AEM;
			end
			pfa_pkg::ST_AEM: begin
				if (out_free) begin
					emit = 1'b1;
					fr_we = 1'b1;
					state_d = last_i ? pfa_pkg::ST_IDLE : pfa_pkg::ST_ARD;
				end
			end
			pfa_pkg::ST_SRCH: begin
				if (idx_q == used_q) begin
					state_d = pfa_pkg::ST_ONE;
				end else if (hit) begin
					if (spages_q[idx_s] == '0) begin
						state_d = pfa_pkg::ST_ONE;
					end else if (cmd_q == pfa_pkg::CMD_DEALLOC) begin
						state_d = pfa_pkg::ST_DRD;
					end else begin
						state_d = pfa_pkg::ST_QRD;
					end
				end
			end
			pfa_pkg::ST_DRD: begin
				fr_re = 1'b1;
				state_d = pfa_pkg::ST_DPUSH;
			end
			pfa_pkg::ST_DPUSH: begin
				ring_we = cnt_q != CW'(FRAMES);
				state_d = last_i ? pfa_pkg::ST_ONE : pfa_pkg::ST_DRD;
			end
			pfa_pkg::ST_QRD: begin
				fr_re = 1'b1;
				state_d = pfa_pkg::ST_QEM;
			end
			pfa_pkg::ST_QEM: begin
				e_frame = fr_rd;
				if (out_free) begin
					emit = 1'b1;
					state_d = last_i ? pfa_pkg::ST_IDLE : pfa_pkg::ST_QRD;
				end
			end
			pfa_pkg::ST_LRD: begin
				ring_re = 1'b1;
				ring_ra = laddr;
				state_d = pfa_pkg::ST_LEM;
			end
			pfa_pkg::ST_LEM: begin
				if (out_free) begin
					emit = 1'b1;
					state_d = last_i ? pfa_pkg::ST_IDLE : pfa_pkg::ST_LRD;
				end
			end
			pfa_pkg::ST_ONE: begin
				e_sts = one_sts_q;
				e_frame = '0;
				e_ev = 1'b0;
				e_pc = one_pc_q;
				e_last = 1'b1;
				if (out_free) begin
					emit = 1'b1;
					state_d = pfa_pkg::ST_IDLE;
				end
			end
			default: state_d = pfa_pkg::ST_IDLE;
		endcase
		if (cfg_fc) begin
			state_d = pfa_pkg::ST_INIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psz_q  <= pfa_pkg::PAGE_SIZE_RST;
			init_q <= '0;
			head_q <= '0;
			cnt_q  <= CW'(FRAMES);
			used_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == pfa_pkg::ST_INIT) begin
				init_q <= init_q + RA_W'(1);
			end
			if (state_q == pfa_pkg::ST_DIV && div_done && !bad && !full) begin
				cnt_q  <= cnt_q - CW'(quo[pfa_pkg::PC_W-1:0]);
				used_q <= used_q + (SW + 1)'(1);
			end
			if (state_q == pfa_pkg::ST_AEM && out_free) begin
				head_q <= head_nx;
			end
			if (ring_we && state_q == pfa_pkg::ST_DPUSH) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cfg_we && cfg_index == pfa_pkg::REG_PAGE_SIZE) begin
				psz_q <= cfg_wdata;
			end
			if (cfg_fc) begin
				init_q <= '0;
				head_q <= '0;
				cnt_q  <= fc_eff;
				used_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= req.command;
			pid_q   <= req.process_id;
			szero_q <= req.request_size_kb == '0;
			idx_q   <= '0;
			i_q     <= '0;
			n_q     <= pfa_pkg::PC_W'(cnt_q);
			one_sts_q <= pfa_pkg::STS_EMPTY;
			one_pc_q  <= '0;
		end
		if (state_q == pfa_pkg::ST_DIV && div_done) begin
			n_q    <= quo[pfa_pkg::PC_W-1:0];
			slot_q <= used_q[SW-1:0];
			one_sts_q <= bad ? pfa_pkg::STS_NOFIT :
				full ? pfa_pkg::STS_FULL : pfa_pkg::STS_OK;
			if (!bad && !full) begin
				owner_q[used_q[SW-1:0]]   <= pid_q;
				spages_q[used_q[SW-1:0]]  <= quo[pfa_pkg::PC_W-1:0];
				removed_q[used_q[SW-1:0]] <= 1'b0;
			end
		end
		if (state_q == pfa_pkg::ST_SRCH) begin
			if (idx_q == used_q) begin
				one_sts_q <= pfa_pkg::STS_NOTFOUND;
			end else if (hit) begin
				slot_q    <= idx_s;
				n_q       <= spages_q[idx_s];
				one_sts_q <= pfa_pkg::STS_OK;
				one_pc_q  <= (cmd_q == pfa_pkg::CMD_DEALLOC) ? spages_q[idx_s] : '0;
				if (cmd_q == pfa_pkg::CMD_DEALLOC) begin
					removed_q[idx_s] <= 1'b1;
				end
			end else begin
				idx_q <= idx_q + (SW + 1)'(1);
			end
		end
		if (emit || state_q == pfa_pkg::ST_DPUSH) begin
			i_q <= i_q + pfa_pkg::IDX_W'(1);
		end
		if (emit) begin
			rsp_status_q <= e_sts;
			rsp_pidx_q   <= e_ev ? i_q : '0;
			rsp_frame_q  <= e_frame;
			rsp_ev_q     <= e_ev;
			rsp_pc_q     <= e_pc;
			rsp_last_q   <= e_last;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.page_index   = rsp_pidx_q;
	assign rsp.frame_number = rsp_frame_q;
	assign rsp.entry_valid  = rsp_ev_q;
	assign rsp.page_count   = rsp_pc_q;
	assign rsp.last         = rsp_last_q;
endmodule
`default_nettype wire

// ===== sv/pfa_checker.sv =====
// ----------------------------------------------------------------------------
// pfa_checker
// Port-level checks of the frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "paging_frame_allocator_macros.svh"
module pfa_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       req_valid,
	input wire logic                       req_ready,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_ready,
	input wire logic [pfa_pkg::STS_W-1:0]  rsp_status,
	input wire logic [pfa_pkg::IDX_W-1:0]  rsp_page_index,
	input wire logic [pfa_pkg::FRM_W-1:0]  rsp_frame_number,
	input wire logic                       rsp_entry_valid,
	input wire logic [pfa_pkg::PC_W-1:0]   rsp_page_count,
	input wire logic                       rsp_last
);
	`PFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
	`PFA_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)
	`PFA_ASSERT_IMPL(a_no_entry_zero, rsp_valid && !rsp_entry_valid, rsp_page_index == '0 && rsp_frame_number == '0)
	`PFA_ASSERT_IMPL(a_err_single, rsp_valid && rsp_status != pfa_pkg::STS_OK, rsp_page_count == '0 && rsp_last && !rsp_entry_valid)
endmodule

bind paging_frame_allocator pfa_checker u_pfa_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_page_index   (rsp.page_index),
	.rsp_frame_number (rsp.frame_number),
	.rsp_entry_valid  (rsp.entry_valid),
	.rsp_page_count   (rsp.page_count),
	.rsp_last         (rsp.last)
);
`default_nettype wire
